// ===== src/tcg_pkg.sv =====
// Shared constants for the text console grid: cell geometry, character codes,
// command opcodes, result kinds and configuration register indexes.
// No dependencies.
`default_nettype none

package tcg_pkg;

  localparam int DEF_COLUMNS = 32;
  localparam int DEF_ROWS    = 16;

  localparam int CELL_W = 6;
  localparam int CELL_H = 8;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_BLANK   = 8'd32;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_MOVE  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] KIND_DRAW   = 2'd0;
  localparam logic [1:0] KIND_REDRAW = 2'd1;
  localparam logic [1:0] KIND_FILL   = 2'd2;

  localparam logic [2:0] REG_ENABLED    = 3'd0;
  localparam logic [2:0] REG_ORIGIN_X   = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Y   = 3'd2;
  localparam logic [2:0] REG_BACKGROUND = 3'd3;

endpackage

`default_nettype wire

// ===== src/text_console_grid_top.sv =====
// Text console grid: command decoder, cursor and scroll control around a
// row-wide character store memory.
// Depends on tcg_pkg.
`default_nettype none

// Usage:
//   Commands enter on start/opcode/char_code/cursor_col/cursor_row and are
//   taken at a clock edge where start is high and busy is low.
//   Results leave on kind/pixel_x/.../last, each valid for one cycle while
//   strobe is high; last marks the final result of a command. The receiver
//   cannot stall, so results are never held back.
//   Configuration writes go through cfg_valid/cfg_index/cfg_data; cfg_ready
//   is always high. Write only while the block is idle.
// Command sequences:
//   put character: result in the cycle after accept, busy during the row
//   read-modify-write through the store memory; newline with no scroll: never busy.
//   scroll: the new bottom row is blanked, then one redraw result per row
//   follows (only the blank when the console is disabled).
//   clear: fill result in the cycle after accept, busy while the store rows are
//   blanked one per cycle.
//   move cursor and unknown opcodes: never busy.
// Reset: synchronous; busy stays high while the store is swept to zero.
//   Configuration writes are taken during the sweep.
module text_console_grid_top #(
  parameter int COLUMNS = tcg_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcg_pkg::DEF_ROWS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  char_code,
  input  wire logic [4:0]  cursor_col,
  input  wire logic [3:0]  cursor_row,
  output logic             strobe,
  output logic [1:0]       kind,
  output logic [15:0]      pixel_x,
  output logic [15:0]      pixel_y,
  output logic [7:0]       glyph,
  output logic [3:0]       store_row,
  output logic [15:0]      fill_width,
  output logic [15:0]      fill_height,
  output logic [15:0]      fill_colour,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import tcg_pkg::*;

  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW = $clog2(ROWS);
  localparam int LW = COLUMNS * 8;
  localparam logic [15:0] FILL_W = 16'(CELL_W * COLUMNS);
  localparam logic [15:0] FILL_H = 16'(CELL_H * ROWS);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_WRITE  = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_REDRAW = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;

  logic [2:0]    state;
  logic [RW-1:0] cnt;
  logic [CW-1:0] col;
  logic [RW-1:0] line;
  logic [RW-1:0] offset;
  logic          scroll_pend;
  logic [RW-1:0] wr_row;
  logic [CW-1:0] wr_col;
  logic [7:0]    wr_char;

  logic          enabled;
  logic [15:0]   origin_x;
  logic [15:0]   origin_y;
  logic [15:0]   background;

  // row-wide character store
  logic [LW-1:0] mem [ROWS];
  logic [LW-1:0] mem_q;
  logic          mem_we;
  logic [RW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic [LW-1:0] merged;
  logic [RW-1:0] cur_phys;

  function automatic logic [RW-1:0] phys(input logic [RW-1:0] r, input logic [RW-1:0] off);
    logic [RW:0] sum;
    sum = {1'b0, r} + {1'b0, off};
    if (sum >= (RW+1)'(ROWS)) begin
      sum = sum - (RW+1)'(ROWS);
    end
    return sum[RW-1:0];
  endfunction

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign cur_phys  = phys(line, offset);

  always_comb begin
    merged = mem_q;
    for (int i = 0; i < COLUMNS; i++) begin
      if (CW'(i) == wr_col) begin
        merged[i*8 +: 8] = wr_char;
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = '0;
    case (state)
      S_INIT: begin
        mem_we = 1'b1;
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {COLUMNS{CHAR_BLANK}};
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = wr_row;
        mem_wdata = merged;
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_waddr = offset;
        mem_wdata = {COLUMNS{CHAR_BLANK}};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[cur_phys];
  end

  // one strobe per redraw cycle, per enabled draw and per clear fill
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == S_REDRAW) ||
                ((state == S_IDLE) && start &&
                 (((opcode == OP_PUT) && (char_code != CHAR_NEWLINE) && enabled) ||
                  (opcode == OP_CLEAR)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      cnt        <= '0;
      col        <= '0;
      line       <= '0;
      offset     <= '0;
      scroll_pend <= 1'b0;
      enabled    <= 1'b0;
      origin_x   <= '0;
      origin_y   <= '0;
      background <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLED:    enabled    <= cfg_data[0];
          REG_ORIGIN_X:   origin_x   <= cfg_data;
          REG_ORIGIN_Y:   origin_y   <= cfg_data;
          REG_BACKGROUND: background <= cfg_data;
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            case (opcode)
              OP_PUT: begin
                if (char_code != CHAR_NEWLINE) begin
                  wr_row      <= cur_phys;
                  wr_col      <= col;
                  wr_char     <= char_code;
                  scroll_pend <= (col == COL_LAST) && (line == ROW_LAST);
                  if (col == COL_LAST) begin
                    col <= '0;
                    if (line != ROW_LAST) begin
                      line <= line + 1'b1;
                    end
                  end else begin
                    col <= col + 1'b1;
                  end
                  if (enabled) begin
                    kind        <= KIND_DRAW;
                    pixel_x     <= origin_x + 16'(CELL_W) * 16'(col);
                    pixel_y     <= origin_y + 16'(CELL_H) * 16'(line);
                    glyph       <= char_code;
                    store_row   <= '0;
                    fill_width  <= '0;
                    fill_height <= '0;
                    fill_colour <= '0;
                    last        <= !((col == COL_LAST) && (line == ROW_LAST));
                  end
                  state <= S_WRITE;
                end else begin
                  col <= '0;
                  if (line == ROW_LAST) begin
                    state <= S_SCROLL;
                  end else begin
                    line <= line + 1'b1;
                  end
                end
              end
              OP_MOVE: begin
                col  <= (32'(cursor_col) < COLUMNS) ? CW'(cursor_col) : COL_LAST;
                line <= (32'(cursor_row) < ROWS) ? RW'(cursor_row) : ROW_LAST;
              end
              OP_CLEAR: begin
                kind        <= KIND_FILL;
                pixel_x     <= origin_x;
                pixel_y     <= origin_y;
                glyph       <= '0;
                store_row   <= '0;
                fill_width  <= FILL_W;
                fill_height <= FILL_H;
                fill_colour <= background;
                last        <= 1'b1;
                col         <= '0;
                line        <= '0;
                cnt         <= '0;
                state       <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_WRITE: begin
          state <= scroll_pend ? S_SCROLL : S_IDLE;
        end
        S_SCROLL: begin
          // new bottom row is the old top row; the top advances past it
          offset <= phys(RW'(1), offset);
          cnt    <= '0;
          state  <= enabled ? S_REDRAW : S_IDLE;
        end
        S_REDRAW: begin
          kind        <= KIND_REDRAW;
          pixel_x     <= origin_x;
          pixel_y     <= origin_y + 16'(CELL_H) * 16'(cnt);
          glyph       <= '0;
          store_row   <= 4'(phys(cnt, offset));
          fill_width  <= '0;
          fill_height <= '0;
          fill_colour <= '0;
          last        <= (cnt == ROW_LAST);
          cnt         <= cnt + 1'b1;
          if (cnt == ROW_LAST) begin
            state <= S_IDLE;
          end
        end
        S_INIT, S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == ROW_LAST) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("store written while idle");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(col) < COLUMNS) && (32'(line) < ROWS))
    else $error("cursor out of grid");

  a_redraw_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind == KIND_REDRAW && last) |-> (state == S_IDLE))
    else $error("redraw sequence did not end with its last row");

  a_clear_fill: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_CLEAR) |=> (strobe && kind == KIND_FILL && last))
    else $error("clear did not produce a fill");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for text_console_grid_top: drives commands and register writes,
// predicts the draw/redraw/fill list and checks every strobed result in order.
// Depends on tcg_pkg and the text_console_grid_top RTL.
`timescale 1ns / 1ps

module testbench;
  import tcg_pkg::*;

  localparam int COLUMNS = DEF_COLUMNS;
  localparam int ROWS = DEF_ROWS;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = ROWS + 4;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  glyph;
    logic [3:0]  srow;
    logic [15:0] fw;
    logic [15:0] fh;
    logic [15:0] fc;
    logic        last;
  } console_result_t;

  // Tracks cursor, scroll offset and registers; keeps the draw list still owed by the block.
  class draw_list_checker;
    bit enabled;
    logic [15:0] org_x, org_y, bg;
    int col, line, top_offset;
    console_result_t pending_draws[$];
    int errors, checked, commands, scrolls, clears;

    function new();
      enabled = 0; org_x = 0; org_y = 0; bg = 0;
      col = 0; line = 0; top_offset = 0;
      errors = 0; checked = 0; commands = 0; scrolls = 0; clears = 0;
    endfunction

    function int pending();
      return pending_draws.size();
    endfunction

    function void write_register(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_ENABLED:    enabled = data[0];
        REG_ORIGIN_X:   org_x = data;
        REG_ORIGIN_Y:   org_y = data;
        REG_BACKGROUND: bg = data;
        default: ;
      endcase
    endfunction

    function void push_draw(logic [1:0] k, logic [15:0] x, logic [15:0] y, logic [7:0] g,
                            logic [3:0] s, logic [15:0] w, logic [15:0] h, logic [15:0] c);
      console_result_t e;
      e = '{k, x, y, g, s, w, h, c, 1'b0};
      pending_draws.push_back(e);
    endfunction

    function void apply_command(logic [1:0] op, logic [7:0] ch, logic [4:0] c, logic [3:0] r);
      int first;
      first = pending_draws.size();
      commands++;
      case (op)
        OP_PUT: begin
          if (ch != CHAR_NEWLINE) begin
            if (enabled)
              push_draw(KIND_DRAW, org_x + 16'(CELL_W * col), org_y + 16'(CELL_H * line),
                        ch, 4'd0, 16'd0, 16'd0, 16'd0);
            col++;
            if (col >= COLUMNS) begin
              col = 0;
              line++;
            end
          end else begin
            col = 0;
            line++;
          end
          if (line >= ROWS) begin
            top_offset = (top_offset + 1) % ROWS;
            scrolls++;
            if (enabled)
              for (int i = 0; i < ROWS; i++)
                push_draw(KIND_REDRAW, org_x, org_y + 16'(CELL_H * i), 8'd0,
                          4'((i + top_offset) % ROWS), 16'd0, 16'd0, 16'd0);
            line = ROWS - 1;
          end
        end
        OP_MOVE: begin
          col = (int'(c) < COLUMNS) ? int'(c) : COLUMNS - 1;
          line = (int'(r) < ROWS) ? int'(r) : ROWS - 1;
        end
        OP_CLEAR: begin
          clears++;
          push_draw(KIND_FILL, org_x, org_y, 8'd0, 4'd0, 16'(CELL_W * COLUMNS),
                    16'(CELL_H * ROWS), bg);
          col = 0;
          line = 0;
        end
        default: ;
      endcase
      if (pending_draws.size() > first)
        pending_draws[pending_draws.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_draw(console_result_t got);
      console_result_t want;
      if (pending_draws.size() == 0) begin
        $display("%0t: result with no transaction pending: expected none, actual kind %0d",
                 $time, got.kind);
        errors++;
        return;
      end
      want = pending_draws.pop_front();
      checked++;
      compare_field("kind", want.kind, got.kind);
      compare_field("pixel_x", want.px, got.px);
      compare_field("pixel_y", want.py, got.py);
      compare_field("glyph", want.glyph, got.glyph);
      compare_field("store_row", want.srow, got.srow);
      compare_field("fill_width", want.fw, got.fw);
      compare_field("fill_height", want.fh, got.fh);
      compare_field("fill_colour", want.fc, got.fc);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] opcode = '0;
  logic [7:0] char_code = '0;
  logic [4:0] cursor_col = '0;
  logic [3:0] cursor_row = '0;
  logic cfg_valid = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic busy, strobe, last, cfg_ready;
  logic [1:0] kind;
  logic [15:0] pixel_x, pixel_y, fill_width, fill_height, fill_colour;
  logic [7:0] glyph;
  logic [3:0] store_row;
  int cycle_count = 0;

  draw_list_checker board = new();

  text_console_grid_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .char_code(char_code), .cursor_col(cursor_col), .cursor_row(cursor_row),
    .strobe(strobe), .kind(kind), .pixel_x(pixel_x), .pixel_y(pixel_y), .glyph(glyph),
    .store_row(store_row), .fill_width(fill_width), .fill_height(fill_height),
    .fill_colour(fill_colour), .last(last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, board.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe)
      board.check_draw(console_result_t'{kind, pixel_x, pixel_y, glyph, store_row,
                                          fill_width, fill_height, fill_colour, last});
  end

  // Call at a rising edge; returns at the edge where the command transaction is taken.
  task automatic issue_command(input logic [1:0] op, input logic [7:0] ch,
                               input logic [4:0] c, input logic [3:0] r);
    start <= 1'b1;
    opcode <= op;
    char_code <= ch;
    cursor_col <= c;
    cursor_row <= r;
    do @(posedge clk); while (busy);
    board.apply_command(op, ch, c, r);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
  endtask

  // Puts and newlines can leave the block busy with no result owed, so settle afterwards.
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic configure(input logic en, input logic [15:0] ox, input logic [15:0] oy,
                           input logic [15:0] bgc);
    logic [2:0] idx[5];
    logic [15:0] val[5];
    idx = '{REG_ENABLED, REG_ORIGIN_X, REG_ORIGIN_Y, REG_BACKGROUND,
            3'($urandom_range(7, 4))};
    val = '{{15'd0, en}, ox, oy, bgc, 16'($urandom_range(65535, 0))};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      board.write_register(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count, input bit allow_idle);
    int done_items;
    int pick;
    logic [1:0] op;
    logic [7:0] ch;
    logic [4:0] c;
    logic [3:0] r;
    done_items = 0;
    while (done_items < count) begin
      pick = $urandom_range(99, 0);
      ch = 8'($urandom_range(255, 0));
      c = 5'($urandom_range(31, 0));
      r = 4'($urandom_range(15, 0));
      if (pick < 55) op = OP_PUT;
      else if (pick < 68) begin
        op = OP_PUT;
        ch = CHAR_NEWLINE;
      end else if (pick < 85) begin
        op = OP_MOVE;
        if (pick[0]) r = 4'(ROWS - 1);  // bottom row often, to reach scrolls quickly
      end else if (pick < 93) op = OP_CLEAR;
      else op = OP_UNUSED;
      issue_command(op, ch, c, r);
      if (op != OP_UNUSED) done_items++;
      if (allow_idle && op != OP_UNUSED && done_items == count / 2)
        wait_drained();
      else if (allow_idle && $urandom_range(3, 0) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(13, 1)) @(posedge clk);
      end
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // enabled, origins at the top of the range so coordinates past the origin wrap
    configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue_command(OP_PUT, 8'h00, 5'd0, 4'd0);
    issue_command(OP_PUT, 8'hFF, 5'd31, 4'd15);
    issue_command(OP_PUT, 8'h41, 5'd0, 4'd0);
    issue_command(OP_PUT, CHAR_NEWLINE, 5'd0, 4'd0);
    issue_command(OP_MOVE, 8'h00, 5'd31, 4'd15);
    issue_command(OP_PUT, 8'h7E, 5'd0, 4'd0);       // column wrap on the last row: scroll
    issue_command(OP_MOVE, 8'hFF, 5'd31, 4'd0);
    issue_command(OP_PUT, CHAR_BLANK, 5'd0, 4'd0);  // column wrap without scroll
    issue_command(OP_MOVE, 8'h00, 5'd0, 4'd15);
    issue_command(OP_PUT, CHAR_NEWLINE, 5'd31, 4'd15);  // newline on the last row: scroll
    issue_command(OP_UNUSED, 8'hFF, 5'd31, 4'd15);
    issue_command(OP_CLEAR, 8'h00, 5'd0, 4'd0);
    issue_command(OP_MOVE, 8'h00, 5'd0, 4'd0);
    issue_command(OP_PUT, 8'h55, 5'd0, 4'd0);
    wait_idle();

    // disabled: stores and scrolls stay silent, clear still fills
    configure(1'b0, 16'h0000, 16'h0000, 16'h0000);
    issue_command(OP_PUT, 8'hAA, 5'd0, 4'd0);
    issue_command(OP_MOVE, 8'h00, 5'd31, 4'd15);
    issue_command(OP_PUT, 8'h01, 5'd0, 4'd0);
    issue_command(OP_MOVE, 8'h00, 5'd5, 4'd15);
    issue_command(OP_PUT, CHAR_NEWLINE, 5'd0, 4'd0);
    issue_command(OP_CLEAR, 8'h00, 5'd0, 4'd0);
    wait_idle();

    configure(1'b1, 16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
              16'($urandom_range(65535, 0)));
    run_random(120, 1'b1);
    wait_idle();

    configure(1'b0, 16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
              16'($urandom_range(65535, 0)));
    run_random(90, 1'b1);
    wait_idle();

    configure(1'b1, 16'($urandom_range(65535, 65400)), 16'($urandom_range(65535, 65400)),
              16'($urandom_range(65535, 0)));
    run_random(130, 1'b1);
    wait_idle();

    configure(1'b1, 16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
              16'($urandom_range(65535, 0)));
    run_random(110, 1'b0);

    wait_drained();
    repeat (SETTLE_CYCLES + 4) @(posedge clk);
    if (board.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, board.pending());
      board.errors++;
    end

    $display("Covered %0d commands (%0d scrolls, %0d clears) and %0d checked results,",
             board.commands, board.scrolls, board.clears, board.checked);
    $display("across enabled/disabled settings with origins at both ends of the range.");
    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
